FILE: sv/sgrr_pkg.sv
// Shared types, constants and the 5x8 column font for the glyph row rasterizer.
`timescale 1ns / 1ps

package sgrr_pkg;

  localparam int MAX_SCALE  = 8;
  localparam int SCALE_W    = 4;
  localparam int REP_W      = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int COLOR_W    = 16;
  localparam int POS_W      = 10;
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 3;
  localparam int GLYPH_COLS = 5;
  localparam int COL_W      = 3;
  localparam int CELL_W     = 6;
  localparam int CELL_H     = 8;
  localparam int FONT_N     = 95;
  localparam int IDX_W      = 7;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;

  localparam logic [CODE_W-1:0]     CODE_FIRST   = 8'h20;
  localparam logic [CODE_W-1:0]     CODE_LAST    = 8'h7E;
  localparam logic [CODE_W-1:0]     CODE_SUBST   = 8'h3F;
  localparam logic [COL_W-1:0]      COL_SPACE    = 3'd5;
  localparam logic [POS_W-1:0]      WIDTH_RESET  = 10'd320;
  localparam logic [POS_W-1:0]      HEIGHT_RESET = 10'd240;
  localparam logic [SCALE_W-1:0]    SCALE_MAX    = SCALE_W'(MAX_SCALE);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0]  REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_HEIGHT   = 2'd1;

  // one classified request, as passed from front to back
  typedef struct packed {
    logic [GLYPH_COLS-1:0] col_bits;
    logic [REP_W-1:0]      scale_m1;
    logic [COLOR_W-1:0]    fg;
    logic [COLOR_W-1:0]    bg;
  } item_t;

  // queue status towards the front
  typedef struct packed {
    logic ready;
    logic valid;
  } q_stat_t;

  localparam logic [7:0] FONT_TABLE [FONT_N][GLYPH_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h0C,8'h52,8'h52,8'h52,8'h3E},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h40,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h08,8'h08,8'h2A,8'h1C,8'h08}
  };

endpackage

FILE: sv/scaled_glyph_row_rasterizer_top.sv
// Top level of the scaled glyph row rasterizer: front, queue and back joined.
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload (lowest bit up)
// s_*       in   s_tvalid/s_tready    char_code, glyph_row, scale, fg_color, bg_color,
//                                     x_pos, y_pos in s_tdata, 67 bits used of 72
// m_*       out  m_tvalid/m_tready    pixel_color in m_tdata, last_pixel on m_tlast
// cfg_*     in   cfg_we               index 0 screen_width, 1 screen_height
//
// An item that passes the clip test gives 6*scale pixels, one a cycle unless the output
// stalls: the back end's column and repeat counters set the rate, and the next item follows
// straight on from the queue. A first pixel passes the front register, the queue, the back
// end's item register and output register. Clipped or bad-scale items are dropped in the front.
// Reset clears the queue and all valid flags and sets the screen to 320 by 240.
// A stalled output holds its pixel; the four-entry queue lets the front keep taking items.

module scaled_glyph_row_rasterizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sgrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgrr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] char_code, [10:8] glyph_row, [14:11] scale, [30:15] fg_color,
  // [46:31] bg_color, [56:47] x_pos, [66:57] y_pos, [71:67] zero
  input  logic [sgrr_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [15:0] pixel_color
  output logic [sgrr_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast
);

  sgrr_pkg::q_stat_t q_stat;
  sgrr_pkg::item_t   push_item;
  sgrr_pkg::item_t   head_item;
  logic              push;
  logic              pop;

  // front: intake, clip test, font row lookup
  sgrr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  sgrr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_stat    (q_stat),
    .head_item (head_item)
  );

  // back: pixel sequencer and output register
  sgrr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: sv/sgrr_front.sv
// Front end: request intake, clip test, font lookup and the register towards the queue.
`timescale 1ns / 1ps

module sgrr_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sgrr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgrr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sgrr_pkg::IN_DATA_W-1:0]       s_tdata,
  input  sgrr_pkg::q_stat_t                    q_stat,
  output logic                                 push,
  output sgrr_pkg::item_t                      push_item
);

  logic [sgrr_pkg::POS_W-1:0]     screen_width;
  logic [sgrr_pkg::POS_W-1:0]     screen_height;
  logic                           f_valid;
  sgrr_pkg::item_t                f_item;

  logic [sgrr_pkg::CODE_W-1:0]    char_code;
  logic [sgrr_pkg::ROW_W-1:0]     glyph_row;
  logic [sgrr_pkg::SCALE_W-1:0]   scale;
  logic [sgrr_pkg::COLOR_W-1:0]   fg_color;
  logic [sgrr_pkg::COLOR_W-1:0]   bg_color;
  logic [sgrr_pkg::POS_W-1:0]     x_pos;
  logic [sgrr_pkg::POS_W-1:0]     y_pos;
  logic [sgrr_pkg::CODE_W-1:0]    code_eff;
  logic [sgrr_pkg::IDX_W-1:0]     font_idx;
  logic [sgrr_pkg::POS_W:0]       x_end;
  logic [sgrr_pkg::POS_W:0]       y_end;
  logic                           keep;
  sgrr_pkg::item_t                new_item;

  assign char_code = s_tdata[7:0];
  assign glyph_row = s_tdata[10:8];
  assign scale     = s_tdata[14:11];
  assign fg_color  = s_tdata[30:15];
  assign bg_color  = s_tdata[46:31];
  assign x_pos     = s_tdata[56:47];
  assign y_pos     = s_tdata[66:57];

  always_comb begin
    if (char_code < sgrr_pkg::CODE_FIRST || char_code > sgrr_pkg::CODE_LAST) begin
      code_eff = sgrr_pkg::CODE_SUBST;
    end else begin
      code_eff = char_code;
    end
    font_idx = sgrr_pkg::IDX_W'(code_eff - sgrr_pkg::CODE_FIRST);

    // 6*scale and 8*scale as shifts
    x_end = {1'b0, x_pos} + (sgrr_pkg::POS_W+1)'({scale, 2'b00})
                          + (sgrr_pkg::POS_W+1)'({scale, 1'b0});
    y_end = {1'b0, y_pos} + (sgrr_pkg::POS_W+1)'({scale, 3'b000});

    keep = (scale != '0) && (scale <= sgrr_pkg::SCALE_MAX)
           && (x_end <= {1'b0, screen_width}) && (y_end <= {1'b0, screen_height});

    for (int c = 0; c < sgrr_pkg::GLYPH_COLS; c++) begin
      new_item.col_bits[c] = sgrr_pkg::FONT_TABLE[font_idx][c][glyph_row];
    end
    new_item.scale_m1 = sgrr_pkg::REP_W'(scale - 1'b1);
    new_item.fg       = fg_color;
    new_item.bg       = bg_color;
  end

  // one register stage; it frees itself whenever the queue takes its item
  assign s_tready  = !f_valid || q_stat.ready;
  assign push      = f_valid && q_stat.ready;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid       <= 1'b0;
      screen_width  <= sgrr_pkg::WIDTH_RESET;
      screen_height <= sgrr_pkg::HEIGHT_RESET;
    end else begin
      if (s_tready) begin
        f_valid <= s_tvalid && keep;
      end
      if (cfg_we) begin
        case (cfg_index)
          sgrr_pkg::REG_WIDTH:  screen_width  <= cfg_data;
          sgrr_pkg::REG_HEIGHT: screen_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid && keep) begin
      f_item <= new_item;
    end
  end

  // an item never lingers once the queue has room
  a_front_drains: assert property (@(posedge clk) disable iff (rst)
    (f_valid && q_stat.ready && !(s_tvalid && keep)) |=> !f_valid)
    else $error("front stage kept an item the queue had taken");

  // a zero scale is never passed on (this check covers zero only)
  a_front_scale: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (scale == '0)) |=> !f_valid)
    else $error("zero-scale request reached the queue");

endmodule

FILE: sv/sgrr_queue.sv
// Small queue of classified items between front and back.
`timescale 1ns / 1ps

module sgrr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sgrr_pkg::item_t   push_item,
  input  logic              pop,
  output sgrr_pkg::q_stat_t q_stat,
  output sgrr_pkg::item_t   head_item
);

  sgrr_pkg::item_t                 mem [sgrr_pkg::Q_DEPTH];
  logic [sgrr_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [sgrr_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [sgrr_pkg::Q_PTR_W:0]      count;

  assign q_stat.ready = (count != (sgrr_pkg::Q_PTR_W+1)'(sgrr_pkg::Q_DEPTH));
  assign q_stat.valid = (count != '0);
  assign head_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> q_stat.ready)
    else $error("queue written while full");

endmodule

FILE: sv/sgrr_back.sv
// Back end: item columns and repeats, one pixel per cycle into the output register unless stalled.
`timescale 1ns / 1ps

module sgrr_back (
  input  logic                               clk,
  input  logic                               rst,
  input  sgrr_pkg::q_stat_t                  q_stat,
  input  sgrr_pkg::item_t                    head_item,
  output logic                               pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sgrr_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);

  logic                          busy;
  sgrr_pkg::item_t               cur;
  logic [sgrr_pkg::COL_W-1:0]    col;
  logic [sgrr_pkg::REP_W-1:0]    rep;
  logic                          adv;
  logic                          last_now;
  logic [sgrr_pkg::COLOR_W-1:0]  color;

  assign adv      = !m_tvalid || m_tready;
  assign last_now = busy && (col == sgrr_pkg::COL_SPACE) && (rep == cur.scale_m1);
  assign pop      = adv && q_stat.valid && (!busy || last_now);

  always_comb begin
    if (col == sgrr_pkg::COL_SPACE) begin
      color = cur.bg;
    end else if (cur.col_bits[col]) begin
      color = cur.fg;
    end else begin
      color = cur.bg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= busy;
      if (pop) begin
        busy <= 1'b1;
      end else if (last_now) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy) begin
        m_tdata <= color;
        m_tlast <= last_now;
      end
      if (pop) begin
        cur <= head_item;
        col <= '0;
        rep <= '0;
      end else if (busy) begin
        if (rep == cur.scale_m1) begin
          rep <= '0;
          col <= col + 1'b1;
        end else begin
          rep <= rep + 1'b1;
        end
      end
    end
  end

  a_back_rep_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rep <= cur.scale_m1))
    else $error("repeat count passed the scale");

  a_back_col_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (col <= sgrr_pkg::COL_SPACE))
    else $error("column count passed the spacing column");

  a_back_last_ends: assert property (@(posedge clk) disable iff (rst)
    (adv && last_now && !q_stat.valid) |=> (!busy && m_tvalid && m_tlast))
    else $error("row end did not close the item");

endmodule

FILE: tb/scaled_glyph_row_rasterizer_top_test.sv
// Self-checking bench for the glyph row rasterizer: random streams against a local row predictor.
`timescale 1ns / 1ps

module scaled_glyph_row_rasterizer_top_test;

  // Geometry and code range of the font
  localparam int unsigned TOP_SCALE  = 8;
  localparam int unsigned GLYPH_W    = 6;     // five font columns plus one spacing column
  localparam int unsigned GLYPH_H    = 8;
  localparam int unsigned FONT_COLS  = 5;
  localparam int unsigned FIRST_CODE = 8'h20;
  localparam int unsigned LAST_CODE  = 8'h7E;
  localparam int unsigned SUBST_CODE = 8'h3F; // '?' stands in for anything unprintable

  // Indexes past the two real registers; writes there must change nothing
  localparam logic [sgrr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [sgrr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [sgrr_pkg::COLOR_W-1:0] WHITE = 16'hFFFF;
  localparam logic [sgrr_pkg::COLOR_W-1:0] BLACK = 16'h0000;

  localparam int unsigned LONG_HOLD     = 600;   // output held off, in cycles
  localparam int unsigned DRAIN_GUARD   = 6000;  // cycles allowed for the tail to drain
  localparam int unsigned SETTLE_CYCLES = 8;     // settle time after a drain; the front absorbs dropped items
  localparam int unsigned LIMIT_NS      = 4_000_000;

  // One row request; declared top field first so the packed value matches s_tdata
  typedef struct packed {
    logic [sgrr_pkg::POS_W-1:0]   y_pos;
    logic [sgrr_pkg::POS_W-1:0]   x_pos;
    logic [sgrr_pkg::COLOR_W-1:0] bg;
    logic [sgrr_pkg::COLOR_W-1:0] fg;
    logic [sgrr_pkg::SCALE_W-1:0] scale;
    logic [sgrr_pkg::ROW_W-1:0]   row;
    logic [sgrr_pkg::CODE_W-1:0]  code;
  } glyph_req_t;

  typedef struct packed {
    logic [sgrr_pkg::COLOR_W-1:0] colour;
    logic                         last;
  } pixel_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_FEW_GAPS} rx_mode_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [sgrr_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [sgrr_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [sgrr_pkg::IN_DATA_W-1:0]    s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [sgrr_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                              m_tlast;

  scaled_glyph_row_rasterizer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor's own view of the screen registers, set only while the block is idle
  logic [sgrr_pkg::POS_W-1:0] scr_width  = 10'd320;
  logic [sgrr_pkg::POS_W-1:0] scr_height = 10'd240;

  glyph_req_t pending_reqs[$];      // waiting for the driver
  pixel_t     expected_pixels[$];   // predicted, not yet seen on the output
  glyph_req_t offered;              // item currently on s_tdata
  bit         in_fire = 1'b0;       // input handshake seen at the last rising edge

  int unsigned mismatch_count = 0;
  int unsigned rows_taken     = 0;
  int unsigned blank_rows     = 0;
  int unsigned pixels_checked = 0;
  int unsigned screens_tried  = 0;

  // Receiver stall control; hold_armed is the one thing the sequence sets here
  bit          hold_armed = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned rx_left    = 0;
  rx_mode_t    rx_mode    = RX_OPEN;

  int unsigned gap_left   = 0;
  int unsigned burst_left = 1;

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Column bytes of one glyph, column 0 in the top byte, bit n of a byte is font row n
  function automatic logic [39:0] font_columns(int unsigned idx);
    case (idx)
      0: return 40'h0000000000;  1: return 40'h00005F0000;  2: return 40'h0007000700;
      3: return 40'h147F147F14;  4: return 40'h242A7F2A12;  5: return 40'h2313086462;
      6: return 40'h3649552250;  7: return 40'h0005030000;  8: return 40'h001C224100;
      9: return 40'h0041221C00; 10: return 40'h14083E0814; 11: return 40'h08083E0808;
     12: return 40'h0050300000; 13: return 40'h0808080808; 14: return 40'h0060600000;
     15: return 40'h2010080402; 16: return 40'h3E5149453E; 17: return 40'h00427F4000;
     18: return 40'h4261514946; 19: return 40'h2141454B31; 20: return 40'h1814127F10;
     21: return 40'h2745454539; 22: return 40'h3C4A494930; 23: return 40'h0171090503;
     24: return 40'h3649494936; 25: return 40'h064949291E; 26: return 40'h0036360000;
     27: return 40'h0056360000; 28: return 40'h0814224100; 29: return 40'h1414141414;
     30: return 40'h0041221408; 31: return 40'h0201510906; 32: return 40'h324979413E;
     33: return 40'h7E1111117E; 34: return 40'h7F49494936; 35: return 40'h3E41414122;
     36: return 40'h7F4141221C; 37: return 40'h7F49494941; 38: return 40'h7F09090901;
     39: return 40'h3E4149497A; 40: return 40'h7F0808087F; 41: return 40'h00417F4100;
     42: return 40'h2040413F01; 43: return 40'h7F08142241; 44: return 40'h7F40404040;
     45: return 40'h7F0204027F; 46: return 40'h7F0408107F; 47: return 40'h3E4141413E;
     48: return 40'h7F09090906; 49: return 40'h3E4151215E; 50: return 40'h7F09192946;
     51: return 40'h4649494931; 52: return 40'h01017F0101; 53: return 40'h3F4040403F;
     54: return 40'h1F2040201F; 55: return 40'h3F4038403F; 56: return 40'h6314081463;
     57: return 40'h0708700807; 58: return 40'h6151494543; 59: return 40'h007F414100;
     60: return 40'h0204081020; 61: return 40'h0041417F00; 62: return 40'h0402010204;
     63: return 40'h4040404040; 64: return 40'h0001020400; 65: return 40'h2054545478;
     66: return 40'h7F48444438; 67: return 40'h3844444420; 68: return 40'h384444487F;
     69: return 40'h3854545418; 70: return 40'h087E090102; 71: return 40'h0C5252523E;
     72: return 40'h7F08040478; 73: return 40'h00447D4000; 74: return 40'h2040443D00;
     75: return 40'h7F10284400; 76: return 40'h00417F4000; 77: return 40'h7C04180478;
     78: return 40'h7C08040478; 79: return 40'h3844444438; 80: return 40'h7C14141408;
     81: return 40'h081414187C; 82: return 40'h7C08040408; 83: return 40'h4854545420;
     84: return 40'h043F444020; 85: return 40'h3C4040407C; 86: return 40'h1C2040201C;
     87: return 40'h3C4030403C; 88: return 40'h4428102844; 89: return 40'h0C5050503C;
     90: return 40'h4464544C44; 91: return 40'h0008364100; 92: return 40'h00007F0000;
     93: return 40'h0041360800; 94: return 40'h08082A1C08;
      default: return '0;
    endcase
  endfunction

  // Works out the pixels one accepted request must give and queues them
  function automatic void rasterize_row(glyph_req_t r);
    int unsigned s;
    int unsigned code;
    int unsigned c;
    int unsigned k;
    logic [39:0] cols;
    logic [7:0]  col_byte;
    pixel_t      px;
    s = r.scale;
    // bad scale, or the whole scaled cell would run past the right or bottom edge
    if (s == 0 || s > TOP_SCALE || r.x_pos + GLYPH_W * s > scr_width ||
        r.y_pos + GLYPH_H * s > scr_height) begin
      blank_rows++;
      return;
    end
    code = r.code;
    if (code < FIRST_CODE || code > LAST_CODE) code = SUBST_CODE;
    cols = font_columns(code - FIRST_CODE);
    for (c = 0; c < GLYPH_W; c++) begin
      px.colour = r.bg;                     // spacing column stays background
      if (c < FONT_COLS) begin
        col_byte = cols[39 - 8 * c -: 8];
        if (col_byte[r.row]) px.colour = r.fg;
      end
      for (k = 0; k < s; k++) begin
        px.last = (c == GLYPH_W - 1) && (k == s - 1);
        expected_pixels.push_back(px);
      end
    end
  endfunction

  function automatic glyph_req_t mk_req(logic [sgrr_pkg::CODE_W-1:0] code,
                                        logic [sgrr_pkg::ROW_W-1:0] row,
                                        logic [sgrr_pkg::SCALE_W-1:0] scale,
                                        logic [sgrr_pkg::COLOR_W-1:0] fg,
                                        logic [sgrr_pkg::COLOR_W-1:0] bg,
                                        logic [sgrr_pkg::POS_W-1:0] x,
                                        logic [sgrr_pkg::POS_W-1:0] y);
    glyph_req_t r;
    r.code = code; r.row = row; r.scale = scale;
    r.fg = fg; r.bg = bg; r.x_pos = x; r.y_pos = y;
    return r;
  endfunction

  // Position on one axis: mostly inside, sometimes on the edge, one past it, or anywhere
  function automatic logic [sgrr_pkg::POS_W-1:0] place_on_axis(int unsigned screen,
                                                               int unsigned extent);
    int          lim;
    int unsigned kind;
    lim  = int'(screen) - int'(extent);
    kind = $urandom_range(0, 24);
    if (kind >= 23 || lim < 0) return sgrr_pkg::POS_W'($urandom_range(0, 1023));
    if (kind >= 21) return sgrr_pkg::POS_W'(lim + 1);
    if (kind >= 19) return sgrr_pkg::POS_W'(lim);
    return sgrr_pkg::POS_W'($urandom_range(lim, 0));
  endfunction

  function automatic glyph_req_t random_request();
    glyph_req_t  r;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)      r.scale = '0;
    else if (pick == 1) r.scale = sgrr_pkg::SCALE_W'($urandom_range(TOP_SCALE + 1, 15));
    else                r.scale = sgrr_pkg::SCALE_W'($urandom_range(1, TOP_SCALE));
    if ($urandom_range(0, 4) == 0) begin
      r.code = sgrr_pkg::CODE_W'($urandom_range(0, 255));
    end else begin
      r.code = sgrr_pkg::CODE_W'($urandom_range(FIRST_CODE, LAST_CODE));
    end
    r.row   = sgrr_pkg::ROW_W'($urandom_range(0, 7));
    r.fg    = sgrr_pkg::COLOR_W'($urandom);
    r.bg    = sgrr_pkg::COLOR_W'($urandom);
    r.x_pos = place_on_axis(scr_width, GLYPH_W * r.scale);
    r.y_pos = place_on_axis(scr_height, GLYPH_H * r.scale);
    return r;
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned i;
    @(posedge clk);
    for (i = 0; i < n; i++) pending_reqs.push_back(random_request());
  endtask

  // Register write at a falling edge; the local copy follows once the edge has passed
  task automatic write_reg(logic [sgrr_pkg::CFG_IDX_W-1:0] idx,
                           logic [sgrr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == sgrr_pkg::REG_WIDTH)       scr_width  = val;
    else if (idx == sgrr_pkg::REG_HEIGHT) scr_height = val;
  endtask

  task automatic set_screen(logic [sgrr_pkg::CFG_DATA_W-1:0] w,
                            logic [sgrr_pkg::CFG_DATA_W-1:0] h);
    write_reg(sgrr_pkg::REG_WIDTH, w);
    write_reg(sgrr_pkg::REG_HEIGHT, h);
    screens_tried++;
  endtask

  // Sender pause: everything offered, every pixel back, then a few quiet cycles
  task automatic drain_and_settle();
    int unsigned guard;
    while (pending_reqs.size() != 0 || s_tvalid) @(posedge clk);
    guard = 0;
    while (expected_pixels.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (expected_pixels.size() != 0) begin
      flag_mismatch($sformatf("%0d predicted pixels never came out", expected_pixels.size()));
      expected_pixels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: bursts of random length, random gaps, item held until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        offered = pending_reqs.pop_front();
        s_tdata  <= sgrr_pkg::IN_DATA_W'(offered);
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output stall pattern: a random mode held for a random run, one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end else begin
        rx_left--;
      end
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:     m_tready <= 1'b1;
          RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
          RX_FEW_GAPS: m_tready <= ($urandom_range(0, 7) != 0);
          default:     m_tready <= 1'b1;
        endcase
      end
    end
  end

  // Both handshakes are read at the rising edge, before the block's registers move
  always @(posedge clk) begin : scoreboard
    pixel_t want;
    in_fire = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_fire = 1'b1;
        rows_taken++;
        rasterize_row(offered);
      end
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch($sformatf("pixel %h last %b with nothing predicted", m_tdata, m_tlast));
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata !== want.colour)
            flag_mismatch($sformatf("pixel %0d colour %h, predicted %h",
                                    pixels_checked, m_tdata, want.colour));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("pixel %0d last %b, predicted %b",
                                    pixels_checked, m_tlast, want.last));
        end
        pixels_checked++;
      end
    end
  end

  initial begin
    int unsigned i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows on the reset screen of 320 by 240
    pending_reqs.push_back(mk_req(8'h20, 3'd0, 4'd1, WHITE, BLACK, 10'd0, 10'd0));
    pending_reqs.push_back(mk_req(8'h7E, 3'd3, 4'd2, WHITE, BLACK, 10'd10, 10'd10));
    // unprintable codes either side of the printable range fall back to '?'
    pending_reqs.push_back(mk_req(8'h00, 3'd0, 4'd1, 16'h1234, 16'hABCD, 10'd5, 10'd5));
    pending_reqs.push_back(mk_req(8'hFF, 3'd4, 4'd3, BLACK, WHITE, 10'd40, 10'd40));
    pending_reqs.push_back(mk_req(8'h1F, 3'd2, 4'd1, WHITE, BLACK, 10'd0, 10'd100));
    pending_reqs.push_back(mk_req(8'h7F, 3'd6, 4'd2, 16'hF800, 16'h07E0, 10'd100, 10'd0));
    // every font row of 'A', row seven blank, scale running up to the maximum
    for (i = 0; i < 8; i++)
      pending_reqs.push_back(mk_req(8'h41, sgrr_pkg::ROW_W'(i), sgrr_pkg::SCALE_W'(i + 1),
                                    (i[0] ? WHITE : BLACK), (i[0] ? BLACK : WHITE),
                                    10'd0, 10'd0));
    // zero scale and scales over the maximum give nothing
    pending_reqs.push_back(mk_req(8'h41, 3'd1, 4'd0, WHITE, BLACK, 10'd0, 10'd0));
    pending_reqs.push_back(mk_req(8'h41, 3'd1, 4'd9, WHITE, BLACK, 10'd0, 10'd0));
    pending_reqs.push_back(mk_req(8'h41, 3'd1, 4'd15, WHITE, BLACK, 10'd0, 10'd0));
    // right and bottom edges: exact fit, then one pixel over
    pending_reqs.push_back(mk_req(8'h42, 3'd0, 4'd4, WHITE, BLACK, 10'd296, 10'd0));
    pending_reqs.push_back(mk_req(8'h42, 3'd0, 4'd4, WHITE, BLACK, 10'd297, 10'd0));
    pending_reqs.push_back(mk_req(8'h43, 3'd5, 4'd4, WHITE, BLACK, 10'd0, 10'd208));
    pending_reqs.push_back(mk_req(8'h43, 3'd5, 4'd4, WHITE, BLACK, 10'd0, 10'd209));
    pending_reqs.push_back(mk_req(8'h44, 3'd1, 4'd1, WHITE, BLACK, 10'd1023, 10'd1023));
    pending_reqs.push_back(mk_req(8'h40, 3'd3, 4'd8, 16'hAAAA, 16'h5555, 10'd272, 10'd176));
    drain_and_settle();

    // Reset screen, random rows; the output is then held off long enough to back up the input
    queue_random(80);
    hold_armed = 1'b1;
    drain_and_settle();

    // Largest screen
    set_screen(10'd1023, 10'd1023);
    queue_random(80);
    drain_and_settle();

    // Writes to the spare indexes must leave the 1023 by 1023 screen as it is
    write_reg(REG_SPARE_A, 10'd3);
    write_reg(REG_SPARE_B, 10'd2);
    queue_random(20);
    drain_and_settle();

    // Tiny and zero screens swallow everything
    set_screen(10'd1, 10'd1);
    queue_random(5);
    drain_and_settle();
    set_screen(10'd0, 10'd0);
    queue_random(5);
    drain_and_settle();

    // Full width but only one scale-1 row of height
    set_screen(10'd1023, 10'd8);
    queue_random(15);
    drain_and_settle();

    // A few random screen sizes
    for (i = 0; i < 3; i++) begin
      set_screen(sgrr_pkg::CFG_DATA_W'($urandom_range(40, 1023)),
                 sgrr_pkg::CFG_DATA_W'($urandom_range(40, 1023)));
      queue_random(25);
      drain_and_settle();
    end

    $display("Covered %0d row requests (%0d drew nothing) over %0d screen sizes,",
             rows_taken, blank_rows, screens_tried);
    $display("%0d pixels compared, with one output hold of %0d cycles.",
             pixels_checked, LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(LIMIT_NS);
    $display("Run timed out with %0d pixels still predicted", expected_pixels.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
